@@ rtl/aeskw_pkg.sv @@
// Shared types, constants and AES byte functions for the key wrap block.
// Used by every module of the block but aeskw_ram; depends on nothing.
`default_nettype none
package aeskw_pkg;

	localparam int MAX_BLOCKS = 32;
	localparam int ADDR_W     = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int T_W        = $clog2(6 * MAX_BLOCKS + 1);
	localparam int WORD_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int RK_ROWS    = 15;
	localparam int RK_IDX_W   = 4;

	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_KSIZE = 3'd4;
	localparam logic [2:0] CFG_IV = 3'd5;
	localparam logic [2:0] CFG_DIR = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INTEG = 2'd1;
	localparam logic [1:0] ST_LEN   = 2'd2;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;

	localparam logic [63:0] IV_RESET = {8{8'hA6}};

	typedef enum logic [3:0] {
		S_LOAD, S_KEXP, S_STEP_RD, S_STEP_GO, S_STEP_WAIT,
		S_FIN, S_OUT_RD, S_OUT_LD, S_OUT_V
	} state_t;

	typedef enum logic [1:0] {OSEL_A, OSEL_RAM, OSEL_ZERO} out_sel_t;
	typedef enum logic {WSEL_IN, WSEL_AES} wsel_t;

	typedef struct packed {
		logic              ram_we;
		logic [ADDR_W-1:0] ram_waddr;
		wsel_t             ram_wsel;
		logic [ADDR_W-1:0] ram_raddr;
		logic              a_load_in;
		logic              a_load_iv;
		logic              a_update;
		logic              kexp_start;
		logic              op_start;
		logic              dec;
		logic [T_W-1:0]    t;
		logic              out_load;
		out_sel_t          out_sel;
		logic [1:0]        out_status;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		logic kexp_done;
		logic op_done;
		logic a_eq_iv;
		logic cfg_dir;
	} sts_t;

	localparam logic [2047:0] SBOX_V = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

	localparam logic [2047:0] ISBOX_V = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX_V[8 * (255 - int'(x)) +: 8];
	endfunction

	function automatic logic [7:0] isbox(input logic [7:0] x);
		return ISBOX_V[8 * (255 - int'(x)) +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s);
		logic [127:0] r;
		for (int b = 0; b < 16; b++) r[8 * b +: 8] = sbox(s[8 * b +: 8]);
		return r;
	endfunction

	function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
		logic [127:0] r;
		for (int b = 0; b < 16; b++) r[8 * b +: 8] = isbox(s[8 * b +: 8]);
		return r;
	endfunction

	// byte b of the state sits at bits [8*(15-b) +: 8]
	function automatic logic [127:0] shift_rows(input logic [127:0] s);
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				r[8 * (15 - (c * 4 + k)) +: 8] = s[8 * (15 - (((c + k) % 4) * 4 + k)) +: 8];
		return r;
	endfunction

	function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				r[8 * (15 - (((c + k) % 4) * 4 + k)) +: 8] = s[8 * (15 - (c * 4 + k)) +: 8];
		return r;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] r;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[8 * (15 - c * 4) +: 8];
			a1 = s[8 * (14 - c * 4) +: 8];
			a2 = s[8 * (13 - c * 4) +: 8];
			a3 = s[8 * (12 - c * 4) +: 8];
			r[8 * (15 - c * 4) +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			r[8 * (14 - c * 4) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			r[8 * (13 - c * 4) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			r[8 * (12 - c * 4) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return r;
	endfunction

	function automatic logic [7:0] gm9(input logic [7:0] x);
		return xtime(xtime(xtime(x))) ^ x;
	endfunction

	function automatic logic [7:0] gm11(input logic [7:0] x);
		return xtime(xtime(xtime(x))) ^ xtime(x) ^ x;
	endfunction

	function automatic logic [7:0] gm13(input logic [7:0] x);
		return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ x;
	endfunction

	function automatic logic [7:0] gm14(input logic [7:0] x);
		return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ xtime(x);
	endfunction

	function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
		logic [127:0] r;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[8 * (15 - c * 4) +: 8];
			a1 = s[8 * (14 - c * 4) +: 8];
			a2 = s[8 * (13 - c * 4) +: 8];
			a3 = s[8 * (12 - c * 4) +: 8];
			r[8 * (15 - c * 4) +: 8] = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
			r[8 * (14 - c * 4) +: 8] = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3);
			r[8 * (13 - c * 4) +: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3);
			r[8 * (12 - c * 4) +: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/aeskw_if.sv @@
// Request channel interfaces: input words and result words.
// Depends on aeskw_pkg for widths.
`default_nettype none
interface aeskw_in_if;
	logic                             valid;
	logic                             ready;
	logic [aeskw_pkg::WORD_W-1:0]     data_word;
	logic                             last_word;
	modport source (output valid, output data_word, output last_word, input ready);
	modport sink (input valid, input data_word, input last_word, output ready);
endinterface

interface aeskw_out_if;
	logic                             valid;
	logic                             ready;
	logic [aeskw_pkg::WORD_W-1:0]     out_word;
	logic [1:0]                       status;
	logic                             out_last;
	modport source (output valid, output out_word, output status, output out_last, input ready);
	modport sink (input valid, input out_word, input status, input out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/aeskw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module aeskw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/aeskw_aes.sv @@
// Iterative AES core: word-serial key expansion into a round key file,
// then one round per cycle for encrypt or decrypt. Depends on aeskw_pkg.
`default_nettype none
module aeskw_aes (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [255:0] key,
	input  wire logic [1:0]   key_size,
	input  wire logic         kexp_start,
	input  wire logic         op_start,
	input  wire logic         op_dec,
	input  wire logic [127:0] op_in,
	output logic              kexp_done,
	output logic              op_done,
	output logic      [127:0] op_out
);
	localparam int RK_ROWS_L = aeskw_pkg::RK_ROWS;

	logic [3:0]  nk_w, nr_w, nr_q;
	logic [2:0]  back_w;
	logic [5:0]  klast_w, kcnt_q;
	logic [2:0]  kmod_q;
	logic [7:0]  rcon_q;
	logic        kact_q, kdone_q;
	logic [31:0] win_q [8];
	logic [127:0] rk_q [RK_ROWS_L];
	logic [31:0] keyw_w, tf_w, kw_w;
	logic        kinit_w, klast_hit_w;

	logic        ract_q, rdec_q, odone_q;
	logic [3:0]  rnd_q;
	logic [127:0] s_q, rkey_w, enc_t_w, dec_t_w, s_next_w;
	logic [aeskw_pkg::RK_IDX_W-1:0] ridx_w;

	always_comb begin
		case (key_size)
			aeskw_pkg::KS_128: begin nk_w = 4'd4; back_w = 3'd4; end
			aeskw_pkg::KS_192: begin nk_w = 4'd6; back_w = 3'd2; end
			default: begin nk_w = 4'd8; back_w = 3'd0; end
		endcase
		nr_w = nk_w + 4'd6;
		klast_w = {nr_w, 2'b00} + 6'd3;
	end

	assign keyw_w = key[(3'd7 - kcnt_q[2:0]) * 32 +: 32];
	assign kinit_w = kcnt_q < 6'(nk_w);
	assign klast_hit_w = kcnt_q == klast_w;

	always_comb begin
		tf_w = win_q[7];
		if (kmod_q == 3'd0) begin
			tf_w = {aeskw_pkg::sbox(win_q[7][23:16]) ^ rcon_q, aeskw_pkg::sbox(win_q[7][15:8]),
				aeskw_pkg::sbox(win_q[7][7:0]), aeskw_pkg::sbox(win_q[7][31:24])};
		end else if (nk_w == 4'd8 && kmod_q == 3'd4) begin
			tf_w = {aeskw_pkg::sbox(win_q[7][31:24]), aeskw_pkg::sbox(win_q[7][23:16]),
				aeskw_pkg::sbox(win_q[7][15:8]), aeskw_pkg::sbox(win_q[7][7:0])};
		end
		kw_w = kinit_w ? keyw_w : (win_q[back_w] ^ tf_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kact_q <= 1'b0;
			kdone_q <= 1'b0;
			kcnt_q <= '0;
			kmod_q <= '0;
			rcon_q <= 8'h01;
			nr_q <= 4'd10;
		end else begin
			kdone_q <= kact_q && klast_hit_w;
			if (kexp_start) begin
				kact_q <= 1'b1;
				kcnt_q <= '0;
				kmod_q <= '0;
				rcon_q <= 8'h01;
				nr_q <= nr_w;
			end else if (kact_q) begin
				kcnt_q <= kcnt_q + 6'd1;
				kmod_q <= (kmod_q == 3'(nk_w - 4'd1)) ? 3'd0 : kmod_q + 3'd1;
				if (kmod_q == 3'd0 && !kinit_w) rcon_q <= aeskw_pkg::xtime(rcon_q);
				if (klast_hit_w) kact_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (kact_q) begin
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i + 1];
			win_q[7] <= kw_w;
			rk_q[kcnt_q[5:2]][(2'd3 - kcnt_q[1:0]) * 32 +: 32] <= kw_w;
		end
	end

	assign ridx_w = op_start ? (op_dec ? nr_q : 4'd0) : rnd_q;
	assign rkey_w = rk_q[ridx_w];
	assign enc_t_w = aeskw_pkg::shift_rows(aeskw_pkg::sub_bytes(s_q));
	assign dec_t_w = aeskw_pkg::inv_shift_rows(aeskw_pkg::inv_sub_bytes(s_q)) ^ rkey_w;

	always_comb begin
		if (rdec_q) begin
			s_next_w = (rnd_q == 4'd0) ? dec_t_w : aeskw_pkg::inv_mix_columns(dec_t_w);
		end else begin
			s_next_w = ((rnd_q == nr_q) ? enc_t_w : aeskw_pkg::mix_columns(enc_t_w)) ^ rkey_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ract_q <= 1'b0;
			rdec_q <= 1'b0;
			odone_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			odone_q <= 1'b0;
			if (op_start) begin
				ract_q <= 1'b1;
				rdec_q <= op_dec;
				rnd_q <= op_dec ? nr_q - 4'd1 : 4'd1;
			end else if (ract_q) begin
				if (rdec_q) begin
					if (rnd_q == 4'd0) begin
						ract_q <= 1'b0;
						odone_q <= 1'b1;
					end else rnd_q <= rnd_q - 4'd1;
				end else begin
					if (rnd_q == nr_q) begin
						ract_q <= 1'b0;
						odone_q <= 1'b1;
					end else rnd_q <= rnd_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_start) s_q <= op_in ^ rkey_w;
		else if (ract_q) s_q <= s_next_w;
	end

	assign kexp_done = kdone_q;
	assign op_done = odone_q;
	assign op_out = s_q;
endmodule
`default_nettype wire

@@ rtl/aeskw_dp.sv @@
// Datapath: configuration registers, integrity word, block store,
// AES core and result register. Depends on aeskw_pkg, aeskw_ram, aeskw_aes.
`default_nettype none
module aeskw_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [aeskw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [aeskw_pkg::WORD_W-1:0]       cfg_data,
	input  wire logic [aeskw_pkg::WORD_W-1:0]       in_word,
	input  wire aeskw_pkg::cmd_t                    cmd,
	output aeskw_pkg::sts_t                         sts,
	output logic      [aeskw_pkg::WORD_W-1:0]       out_word,
	output logic      [1:0]                         out_status,
	output logic                                    out_last
);
	logic [63:0]  key_q [4];
	logic [1:0]   ksize_q;
	logic [63:0]  iv_q;
	logic         dir_q;
	logic [63:0]  a_q, ram_rdata, ram_wdata, t_w;
	logic [127:0] aes_out;
	logic         kexp_done, op_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			ksize_q <= '0;
			iv_q <= aeskw_pkg::IV_RESET;
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				aeskw_pkg::CFG_KEY0: key_q[0] <= cfg_data;
				aeskw_pkg::CFG_KEY1: key_q[1] <= cfg_data;
				aeskw_pkg::CFG_KEY2: key_q[2] <= cfg_data;
				aeskw_pkg::CFG_KEY3: key_q[3] <= cfg_data;
				aeskw_pkg::CFG_KSIZE: ksize_q <= cfg_data[1:0];
				aeskw_pkg::CFG_IV: iv_q <= cfg_data;
				aeskw_pkg::CFG_DIR: dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign t_w = 64'(cmd.t);
	assign ram_wdata = (cmd.ram_wsel == aeskw_pkg::WSEL_IN) ? in_word : aes_out[63:0];

	aeskw_ram #(.WIDTH(64), .DEPTH(aeskw_pkg::MAX_BLOCKS)) u_store (
		.clk(clk), .we(cmd.ram_we), .waddr(cmd.ram_waddr), .wdata(ram_wdata),
		.raddr(cmd.ram_raddr), .rdata(ram_rdata)
	);

	aeskw_aes u_aes (
		.clk(clk), .arst_n(arst_n),
		.key({key_q[0], key_q[1], key_q[2], key_q[3]}), .key_size(ksize_q),
		.kexp_start(cmd.kexp_start), .op_start(cmd.op_start), .op_dec(cmd.dec),
		.op_in({cmd.dec ? (a_q ^ t_w) : a_q, ram_rdata}),
		.kexp_done(kexp_done), .op_done(op_done), .op_out(aes_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) a_q <= '0;
		else if (cmd.a_load_in) a_q <= in_word;
		else if (cmd.a_load_iv) a_q <= iv_q;
		else if (cmd.a_update) a_q <= aes_out[127:64] ^ (cmd.dec ? 64'd0 : t_w);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				aeskw_pkg::OSEL_A: out_word <= a_q;
				aeskw_pkg::OSEL_RAM: out_word <= ram_rdata;
				default: out_word <= '0;
			endcase
			out_status <= cmd.out_status;
			out_last <= cmd.out_last;
		end
	end

	assign sts.kexp_done = kexp_done;
	assign sts.op_done = op_done;
	assign sts.a_eq_iv = a_q == iv_q;
	assign sts.cfg_dir = dir_q;
endmodule
`default_nettype wire

@@ rtl/aeskw_ctrl.sv @@
// Controller: frame loading, pass and block sequencing, result emission.
// Depends on aeskw_pkg; drives aeskw_dp through cmd_t.
`default_nettype none
module aeskw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire aeskw_pkg::sts_t   sts,
	output aeskw_pkg::cmd_t        cmd
);
	localparam int AW = aeskw_pkg::ADDR_W;
	localparam int CW = aeskw_pkg::CNT_W;
	localparam int TW = aeskw_pkg::T_W;

	aeskw_pkg::state_t state_q, state_n;
	logic          frame_q, frame_n, dir_q, dir_n, hdr_q, hdr_n, ovf_q, ovf_n;
	logic          lastout_q, lastout_n;
	logic [CW-1:0] wcnt_q, wcnt_n, n_q, n_n;
	logic [AW-1:0] idx_q, idx_n, k_q, k_n;
	logic [2:0]    pass_q, pass_n;
	logic [TW-1:0] t_q, t_n;
	logic          cur_dir, cur_hdr, cur_ovf, step_end;
	logic [CW-1:0] cur_wcnt;
	logic [AW-1:0] nm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aeskw_pkg::S_LOAD;
			frame_q <= 1'b0;
			dir_q <= 1'b0;
			hdr_q <= 1'b0;
			ovf_q <= 1'b0;
			lastout_q <= 1'b0;
			wcnt_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			pass_q <= '0;
			t_q <= '0;
		end else begin
			state_q <= state_n;
			frame_q <= frame_n;
			dir_q <= dir_n;
			hdr_q <= hdr_n;
			ovf_q <= ovf_n;
			lastout_q <= lastout_n;
			wcnt_q <= wcnt_n;
			n_q <= n_n;
			idx_q <= idx_n;
			k_q <= k_n;
			pass_q <= pass_n;
			t_q <= t_n;
		end
	end

	assign cur_dir = frame_q ? dir_q : sts.cfg_dir;
	assign cur_hdr = frame_q && hdr_q;
	assign cur_ovf = frame_q && ovf_q;
	assign cur_wcnt = frame_q ? wcnt_q : '0;
	assign nm1 = AW'(n_q - CW'(1));
	assign step_end = dir_q ? (idx_q == '0 && pass_q == 3'd0)
		: (idx_q == nm1 && pass_q == 3'd5);

	always_comb begin
		state_n = state_q;
		frame_n = frame_q;
		dir_n = dir_q;
		hdr_n = hdr_q;
		ovf_n = ovf_q;
		lastout_n = lastout_q;
		wcnt_n = wcnt_q;
		n_n = n_q;
		idx_n = idx_q;
		k_n = k_q;
		pass_n = pass_q;
		t_n = t_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		cmd.dec = dir_q;
		cmd.t = t_q;
		cmd.ram_raddr = idx_q;
		cmd.ram_waddr = idx_q;
		cmd.ram_wsel = aeskw_pkg::WSEL_AES;
		cmd.out_sel = aeskw_pkg::OSEL_ZERO;
		cmd.out_status = aeskw_pkg::ST_OK;

		case (state_q)
			aeskw_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dir_n = cur_dir;
					hdr_n = cur_hdr;
					ovf_n = cur_ovf;
					wcnt_n = cur_wcnt;
					if (cur_dir && !cur_hdr) begin
						cmd.a_load_in = 1'b1;
						hdr_n = 1'b1;
					end else if (cur_wcnt < CW'(aeskw_pkg::MAX_BLOCKS)) begin
						cmd.ram_we = 1'b1;
						cmd.ram_waddr = cur_wcnt[AW-1:0];
						cmd.ram_wsel = aeskw_pkg::WSEL_IN;
						wcnt_n = cur_wcnt + CW'(1);
					end else begin
						ovf_n = 1'b1;
					end
					if (in_last) begin
						frame_n = 1'b0;
						n_n = wcnt_n;
						if (ovf_n || wcnt_n == '0) begin
							cmd.out_load = 1'b1;
							cmd.out_sel = aeskw_pkg::OSEL_ZERO;
							cmd.out_status = aeskw_pkg::ST_LEN;
							cmd.out_last = 1'b1;
							lastout_n = 1'b1;
							state_n = aeskw_pkg::S_OUT_V;
						end else begin
							cmd.kexp_start = 1'b1;
							state_n = aeskw_pkg::S_KEXP;
						end
					end else begin
						frame_n = 1'b1;
					end
				end
			end
			aeskw_pkg::S_KEXP: begin
				if (sts.kexp_done) begin
					if (dir_q) begin
						t_n = TW'({n_q, 2'b00}) + TW'({n_q, 1'b0});
						idx_n = nm1;
						pass_n = 3'd5;
					end else begin
						cmd.a_load_iv = 1'b1;
						t_n = TW'(1);
						idx_n = '0;
						pass_n = 3'd0;
					end
					state_n = aeskw_pkg::S_STEP_RD;
				end
			end
			aeskw_pkg::S_STEP_RD: state_n = aeskw_pkg::S_STEP_GO;
			aeskw_pkg::S_STEP_GO: begin
				cmd.op_start = 1'b1;
				state_n = aeskw_pkg::S_STEP_WAIT;
			end
			aeskw_pkg::S_STEP_WAIT: begin
				if (sts.op_done) begin
					cmd.a_update = 1'b1;
					cmd.ram_we = 1'b1;
					if (step_end) begin
						state_n = aeskw_pkg::S_FIN;
					end else begin
						state_n = aeskw_pkg::S_STEP_RD;
						if (dir_q) begin
							t_n = t_q - TW'(1);
							if (idx_q == '0) begin
								idx_n = nm1;
								pass_n = pass_q - 3'd1;
							end else idx_n = idx_q - AW'(1);
						end else begin
							t_n = t_q + TW'(1);
							if (idx_q == nm1) begin
								idx_n = '0;
								pass_n = pass_q + 3'd1;
							end else idx_n = idx_q + AW'(1);
						end
					end
				end
			end
			aeskw_pkg::S_FIN: begin
				k_n = '0;
				if (!dir_q) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = aeskw_pkg::OSEL_A;
					lastout_n = 1'b0;
					state_n = aeskw_pkg::S_OUT_V;
				end else if (sts.a_eq_iv) begin
					state_n = aeskw_pkg::S_OUT_RD;
				end else begin
					cmd.out_load = 1'b1;
					cmd.out_status = aeskw_pkg::ST_INTEG;
					cmd.out_last = 1'b1;
					lastout_n = 1'b1;
					state_n = aeskw_pkg::S_OUT_V;
				end
			end
			aeskw_pkg::S_OUT_RD: begin
				cmd.ram_raddr = k_q;
				state_n = aeskw_pkg::S_OUT_LD;
			end
			aeskw_pkg::S_OUT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_sel = aeskw_pkg::OSEL_RAM;
				cmd.out_last = k_q == nm1;
				lastout_n = k_q == nm1;
				k_n = k_q + AW'(1);
				state_n = aeskw_pkg::S_OUT_V;
			end
			aeskw_pkg::S_OUT_V: begin
				out_valid = 1'b1;
				if (out_ready) state_n = lastout_q ? aeskw_pkg::S_LOAD : aeskw_pkg::S_OUT_RD;
			end
			default: state_n = aeskw_pkg::S_LOAD;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/aes_key_wrap_unwrap.sv @@
// Top level of the AES key wrap / unwrap block: controller plus datapath.
// Depends on aeskw_pkg, aeskw_if, aeskw_ctrl, aeskw_dp.
//
// Channel   Kind        Payload
// in_ch     request in  data_word[63:0], last_word
// out_ch    request out out_word[63:0], status[1:0], out_last
// cfg       write only  cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// Words load at one per cycle. After the last word, key expansion runs,
// then 6*n block steps; each step reads the block store, then runs Nr AES
// rounds at one round per cycle, where Nr is 10, 12 or 14 for 128, 192 or
// 256-bit keys. The first result is loaded after the last step; each later
// one is read from the block store and waits on any stall from out_ch.ready.
// Input is held off from the last word until the final result is taken.
// Reset clears control state, configuration registers and the integrity word; the block store needs no clearing.
`default_nettype none
module aes_key_wrap_unwrap (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [aeskw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aeskw_pkg::WORD_W-1:0]    cfg_data,
	aeskw_in_if.sink                             in_ch,
	aeskw_out_if.source                          out_ch
);
	aeskw_pkg::cmd_t cmd;
	aeskw_pkg::sts_t sts;

	aeskw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.last_word), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	aeskw_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_word(in_ch.data_word), .cmd(cmd), .sts(sts),
		.out_word(out_ch.out_word), .out_status(out_ch.status), .out_last(out_ch.out_last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input accepted while a result is pending");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != aeskw_pkg::ST_OK |-> out_ch.out_last && out_ch.out_word == '0)
		else $error("error result not a single zero word");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.last_word |=> !in_ch.ready)
		else $error("input still open after last word");
endmodule
`default_nettype wire
